// ===== rtl/tcq_pkg.sv =====
`timescale 1ns / 1ps
// tcq_pkg: shared types, codes and constants for the two-class ticket queue.
// Depends on nothing; imported by two_class_ticket_queue_core and its bench.
package tcq_pkg;

	// Default queue depth
	localparam int DEPTH_DEF = 16;

	// Highest sequence number before the per-category counter wraps to 1
	localparam logic [9:0] NUM_MAX = 10'd999;
	localparam logic [9:0] NUM_FIRST = 10'd1;

	// Request kinds
	localparam logic [1:0] FN_ISSUE  = 2'd0;
	localparam logic [1:0] FN_SERVE  = 2'd1;
	localparam logic [1:0] FN_CANCEL = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	// Category that is queued ahead of all others
	localparam logic [1:0] CAT_PRIORITY = 2'd0;

	// Request item
	typedef struct packed {
		logic [1:0] func;
		logic [1:0] category;
		logic [9:0] ticket_number;
	} req_item_t;

	// Result item
	typedef struct packed {
		logic [1:0] status;
		logic [1:0] out_category;
		logic [9:0] out_number;
		logic [4:0] queue_count;
	} rsp_item_t;

	// One queue slot as held in memory
	typedef struct packed {
		logic [1:0] cat;
		logic [9:0] num;
	} slot_t;

	// Sequencer states: issue a read, act on the read data, hand off the result
	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_RD,
		SQ_OP,
		SQ_FIN
	} seq_state_t;

	// What the current walk over the queue is doing
	typedef enum logic [2:0] {
		MD_SCAN,    // skip the leading run of priority tickets
		MD_INSERT,  // ripple a carried slot one place toward the tail
		MD_SERVE,   // fetch the head
		MD_SEARCH,  // look for the ticket to cancel
		MD_REMOVE   // close the gap, moving each slot one place toward the head
	} walk_mode_t;

endpackage

// ===== rtl/two_class_ticket_queue_core.sv =====
`timescale 1ns / 1ps
// two_class_ticket_queue_core: ordered ticket queue with priority insert and cancel.
// Depends on tcq_pkg (types, codes, constants).
//
//  Channel  Signals                      Dir  Payload
//  request  req_valid / req_ready / req   in  func, category, ticket_number
//  result   rsp_valid / rsp_ready / rsp  out  status, out_category, out_number,
//                                              queue_count
//
// A plain issue or a rejected request goes from idle straight to finish; a priority
// issue, serve or cancel walks the slot memory, reading each slot visited and then
// acting on it and writing it back. The registered read port of the slot memory
// sets the step. One item is worked on at a time; the result sits in an output
// register so the next item is taken while it waits. Reset clears the count and
// the counters; the slot memory needs no clearing.
module two_class_ticket_queue_core
	import tcq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	// Control and datapath registers
	seq_state_t state_q, state_d;
	walk_mode_t mode_q, mode_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] cnt_q, cnt_d;
	slot_t carry_q, carry_d;
	req_item_t req_q, req_d;
	rsp_item_t res_q, res_d;
	rsp_item_t rsp_q, rsp_d;
	logic rsp_valid_q, rsp_valid_d;
	logic [9:0] ctr_q [4];
	logic ctr_we;
	logic [9:0] ctr_nxt;
	logic [9:0] ctr_cur;
	logic [CW-1:0] idx_inc;

	// Slot memory ports
	slot_t mem [DEPTH];
	logic wr_en;
	logic [AW-1:0] wr_addr;
	slot_t wr_data;
	logic rd_en;
	logic [AW-1:0] rd_addr;
	slot_t rd_data_q;

	assign req_ready = (state_q == SQ_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
	assign idx_inc = idx_q + 1'b1;

	// Next number for the requested category
	assign ctr_cur = ctr_q[req.category];
	assign ctr_nxt = (ctr_cur >= NUM_MAX) ? NUM_FIRST : ctr_cur + 10'd1;

	// Slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state, memory accesses and datapath updates
	always_comb begin
		state_d = state_q;
		mode_d = mode_q;
		idx_d = idx_q;
		cnt_d = cnt_q;
		carry_d = carry_q;
		req_d = req_q;
		res_d = res_q;
		rsp_d = rsp_q;
		rsp_valid_d = rsp_valid_q && !rsp_ready;
		ctr_we = 1'b0;
		wr_en = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_data = carry_q;
		rd_en = 1'b0;
		rd_addr = idx_q[AW-1:0];

		case (state_q)
			SQ_IDLE: begin
				if (req_valid) begin
					req_d = req;
					idx_d = '0;
					res_d = '0;
					state_d = SQ_FIN;
					case (req.func)
						FN_ISSUE: begin
							res_d.out_category = req.category;
							if (cnt_q == DEPTH_C) begin
								res_d.status = ST_FULL;
							end else begin
								ctr_we = 1'b1;
								res_d.out_number = ctr_nxt;
								if (req.category == CAT_PRIORITY) begin
									carry_d = '{cat: req.category, num: ctr_nxt};
									mode_d = MD_SCAN;
									state_d = SQ_RD;
								end else begin
									// Plain ticket goes straight to the tail
									wr_en = 1'b1;
									wr_addr = cnt_q[AW-1:0];
									wr_data = '{cat: req.category, num: ctr_nxt};
									cnt_d = cnt_q + 1'b1;
								end
							end
						end
						FN_SERVE: begin
							if (cnt_q == '0) begin
								res_d.status = ST_EMPTY;
							end else begin
								mode_d = MD_SERVE;
								state_d = SQ_RD;
							end
						end
						FN_CANCEL: begin
							if (cnt_q == '0) begin
								res_d.status = ST_EMPTY;
							end else begin
								mode_d = MD_SEARCH;
								state_d = SQ_RD;
							end
						end
						default: begin
						end
					endcase
				end
			end

			SQ_RD: begin
				state_d = SQ_OP;
				case (mode_q)
					MD_SCAN, MD_INSERT: begin
						if (idx_q == cnt_q) begin
							// Reached the tail: drop the carried slot there
							wr_en = 1'b1;
							cnt_d = cnt_q + 1'b1;
							state_d = SQ_FIN;
						end else begin
							rd_en = 1'b1;
						end
					end
					MD_SEARCH: begin
						if (idx_q == cnt_q) begin
							res_d.status = ST_NOT_FOUND;
							state_d = SQ_FIN;
						end else begin
							rd_en = 1'b1;
						end
					end
					MD_REMOVE: begin
						if (idx_inc >= cnt_q) begin
							cnt_d = cnt_q - 1'b1;
							state_d = SQ_FIN;
						end else begin
							rd_en = 1'b1;
							rd_addr = idx_inc[AW-1:0];
						end
					end
					default: begin
						// Serve reads the head
						rd_en = 1'b1;
					end
				endcase
			end

			SQ_OP: begin
				state_d = SQ_RD;
				case (mode_q)
					MD_SCAN: begin
						if (rd_data_q.cat == CAT_PRIORITY) begin
							idx_d = idx_inc;
						end else begin
							wr_en = 1'b1;
							carry_d = rd_data_q;
							idx_d = idx_inc;
							mode_d = MD_INSERT;
						end
					end
					MD_INSERT: begin
						wr_en = 1'b1;
						carry_d = rd_data_q;
						idx_d = idx_inc;
					end
					MD_SEARCH: begin
						if (rd_data_q.cat == req_q.category &&
						    rd_data_q.num == req_q.ticket_number) begin
							res_d.out_category = req_q.category;
							res_d.out_number = req_q.ticket_number;
							mode_d = MD_REMOVE;
						end else begin
							idx_d = idx_inc;
						end
					end
					MD_REMOVE: begin
						wr_en = 1'b1;
						wr_data = rd_data_q;
						idx_d = idx_inc;
					end
					default: begin
						// Serve: hand out the head, then close the gap at slot 0
						res_d.out_category = rd_data_q.cat;
						res_d.out_number = rd_data_q.num;
						mode_d = MD_REMOVE;
					end
				endcase
			end

			SQ_FIN: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_d = res_q;
					rsp_d.queue_count = 5'(cnt_q);
					rsp_valid_d = 1'b1;
					state_d = SQ_IDLE;
				end
			end

			default: begin
				state_d = SQ_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rsp_valid_q <= 1'b0;
			mode_q <= MD_SCAN;
			ctr_q[0] <= '0;
			ctr_q[1] <= '0;
			ctr_q[2] <= '0;
			ctr_q[3] <= '0;
		end else begin
			cnt_q <= cnt_d;
			rsp_valid_q <= rsp_valid_d;
			mode_q <= mode_d;
			if (ctr_we) begin
				ctr_q[req.category] <= ctr_nxt;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		carry_q <= carry_d;
		req_q <= req_d;
		res_q <= res_d;
		rsp_q <= rsp_d;
	end

	// The queue never holds more than DEPTH tickets
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("ticket count above depth");

	// Reads and writes of the slot memory never meet in one cycle
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("slot memory read and write in the same cycle");

	// The count only moves as a request finishes
	a_cnt_at_finish: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> state_q == SQ_FIN)
		else $error("ticket count changed outside finish");

	// A result waiting on a stalled output is held
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

endmodule

// ===== tb/tb_two_class_ticket_queue_core.sv =====
`timescale 1ns / 1ps
// tb_two_class_ticket_queue_core: self-checking bench for the two-class ticket queue.
// Depends on tcq_pkg and two_class_ticket_queue_core; a local queue model predicts
// every result, and the results are checked in order under random idling on both sides.
module tb_two_class_ticket_queue_core;
	import tcq_pkg::*;

	localparam int DEPTH = DEPTH_DEF;

	// Request kind with no meaning; the block answers it and changes nothing
	localparam logic [1:0] FN_UNUSED = 2'd3;

	// Ticket classes other than priority
	localparam logic [1:0] CAT_ACCOUNT  = 2'd1;
	localparam logic [1:0] CAT_TRANSFER = 2'd2;
	localparam logic [1:0] CAT_BALANCE  = 2'd3;

	localparam int LONG_HOLD   = 300;
	localparam int SETTLE      = 2 * DEPTH + 8;
	localparam int RANDOM_ITEMS = 450;
	localparam int MAX_REPORTS = 100;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_item_t req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_item_t rsp;

	// Queue model: head at index 0, plus last number handed out per class
	slot_t      line_up[$];
	logic [9:0] last_issued[4] = '{default: 10'd0};

	// Results still owed by the block, oldest first
	rsp_item_t  owed_results[$];

	int err_count = 0;
	int send_idle_pct = 0;
	int take_idle_pct = 0;
	int holds_asked = 0;
	int holds_taken = 0;
	int hold_left = 0;

	two_class_ticket_queue_core #(
		.DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Work out the answer to one request and move the queue model on
	function automatic rsp_item_t apply_request(input req_item_t r);
		rsp_item_t  res;
		int         pos;
		int         hit;
		logic [9:0] nxt;
		slot_t      s;
		res = '0;
		case (r.func)
		FN_ISSUE: begin
			res.out_category = r.category;
			if (line_up.size() >= DEPTH) begin
				res.status = ST_FULL;
			end else begin
				nxt = (last_issued[r.category] >= NUM_MAX) ? NUM_FIRST :
					last_issued[r.category] + 10'd1;
				last_issued[r.category] = nxt;
				pos = line_up.size();
				// priority goes behind the leading run of priority tickets
				if (r.category == CAT_PRIORITY) begin
					pos = 0;
					while (pos < line_up.size() && line_up[pos].cat == CAT_PRIORITY)
						pos++;
				end
				s.cat = r.category;
				s.num = nxt;
				line_up.insert(pos, s);
				res.out_number = nxt;
			end
		end
		FN_SERVE: begin
			if (line_up.size() == 0) begin
				res.status = ST_EMPTY;
			end else begin
				s = line_up.pop_front();
				res.out_category = s.cat;
				res.out_number = s.num;
			end
		end
		FN_CANCEL: begin
			if (line_up.size() == 0) begin
				res.status = ST_EMPTY;
			end else begin
				hit = -1;
				for (int i = 0; i < line_up.size() && hit < 0; i++) begin
					if (line_up[i].cat == r.category && line_up[i].num == r.ticket_number)
						hit = i;
				end
				if (hit >= 0) begin
					line_up.delete(hit);
					res.out_category = r.category;
					res.out_number = r.ticket_number;
				end else begin
					res.status = ST_NOT_FOUND;
				end
			end
		end
		default: ;
		endcase
		res.queue_count = 5'(line_up.size());
		return res;
	endfunction

	function automatic req_item_t make_req(input logic [1:0] f, input logic [1:0] c,
			input logic [9:0] n);
		req_item_t r;
		r.func = f;
		r.category = c;
		r.ticket_number = n;
		return r;
	endfunction

	// Random request, mostly well formed: cancels usually name a queued ticket
	function automatic req_item_t random_req(input bit filling);
		req_item_t r;
		int        roll;
		int        pick;
		roll = $urandom_range(99);
		r.category = 2'($urandom_range(3));
		r.ticket_number = 10'($urandom_range(1023));
		if (roll < (filling ? 55 : 20)) begin
			r.func = FN_ISSUE;
			if ($urandom_range(2) == 0)
				r.category = CAT_PRIORITY;
		end else if (roll < (filling ? 70 : 55)) begin
			r.func = FN_SERVE;
		end else if (roll < (filling ? 88 : 85) && line_up.size() > 0) begin
			r.func = FN_CANCEL;
			pick = $urandom_range(line_up.size() - 1);
			r.category = line_up[pick].cat;
			r.ticket_number = line_up[pick].num;
		end else if (roll < 96) begin
			// near misses: small numbers that exist under some other class
			r.func = FN_CANCEL;
			if ($urandom_range(1) == 0)
				r.ticket_number = 10'($urandom_range(20));
		end else begin
			r.func = FN_UNUSED;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (err_count < MAX_REPORTS)
			$display("%0t ns: mismatch: %s", $time, msg);
		err_count++;
	endtask

	task automatic check_result(input rsp_item_t got, input rsp_item_t want);
		if (got.status !== want.status)
			report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
		if (got.out_category !== want.out_category)
			report_mismatch($sformatf("out_category %0d, expected %0d",
				got.out_category, want.out_category));
		if (got.out_number !== want.out_number)
			report_mismatch($sformatf("out_number %0d, expected %0d",
				got.out_number, want.out_number));
		if (got.queue_count !== want.queue_count)
			report_mismatch($sformatf("queue_count %0d, expected %0d",
				got.queue_count, want.queue_count));
	endtask

	// Offer one item, with random gaps ahead of it; predict when it is taken
	task automatic send_request(input req_item_t item);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		owed_results.push_back(apply_request(item));
	endtask

	// Result side: random stalls, plus a long hold when one is asked for
	always @(negedge clk) begin
		if (holds_taken != holds_asked) begin
			holds_taken = holds_asked;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= take_idle_pct);
		end
	end

	// Compare every result taken with the oldest one owed
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (owed_results.size() == 0)
				report_mismatch("result with no request outstanding");
			else
				check_result(rsp, owed_results.pop_front());
		end
	end

	// Empty queue answers, class ordering, cancel hits and misses, full queue
	task automatic test_directed();
		send_request(make_req(FN_SERVE, CAT_BALANCE, 10'd1023));
		send_request(make_req(FN_CANCEL, CAT_PRIORITY, 10'd1));
		send_request(make_req(FN_UNUSED, CAT_BALANCE, 10'd1023));
		send_request(make_req(FN_ISSUE, CAT_ACCOUNT, 10'd0));
		send_request(make_req(FN_ISSUE, CAT_PRIORITY, 10'd0));
		send_request(make_req(FN_ISSUE, CAT_PRIORITY, 10'd1023));
		send_request(make_req(FN_ISSUE, CAT_TRANSFER, 10'd0));
		send_request(make_req(FN_ISSUE, CAT_BALANCE, 10'd0));
		send_request(make_req(FN_CANCEL, CAT_TRANSFER, 10'd1));
		send_request(make_req(FN_CANCEL, CAT_ACCOUNT, 10'd0));
		send_request(make_req(FN_CANCEL, CAT_BALANCE, 10'd1023));
		// fill to the brim, then one issue too many
		for (int i = 0; i < 12; i++)
			send_request(make_req(FN_ISSUE, 2'(i), 10'(i * 85)));
		send_request(make_req(FN_ISSUE, CAT_PRIORITY, 10'd512));
		send_request(make_req(FN_SERVE, CAT_PRIORITY, 10'd0));
	endtask

	// Random traffic that swings the fill level between full and empty
	task automatic test_random_mix(input int n);
		bit filling;
		filling = 1'b0;
		for (int k = 0; k < n; k++) begin
			if (k % 40 == 0)
				filling = ~filling;
			send_request(random_req(filling));
		end
	endtask

	// Hold results back while requests keep coming, so the input stalls
	task automatic test_result_backpressure();
		holds_asked++;
		for (int k = 0; k < 40; k++)
			send_request(random_req(1'b1));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 14;
		take_idle_pct = 78;
		test_directed();
		test_random_mix(RANDOM_ITEMS);

		send_idle_pct = 78;
		take_idle_pct = 14;
		test_random_mix(RANDOM_ITEMS);

		send_idle_pct = 0;
		take_idle_pct = 0;
		test_result_backpressure();
		test_random_mix(RANDOM_ITEMS);

		@(negedge clk);
		req_valid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (err_count == 0)
			$display("tb_two_class_ticket_queue_core passed");
		else
			$display("tb_two_class_ticket_queue_core failed");
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#10_000_000;
		$display("tb_two_class_ticket_queue_core failed");
		$finish;
	end

endmodule
